FILE: hdl/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the button press/hold/rapid classifier.
package bpc_pkg;

    localparam int IDX_W   = 6;
    localparam int LEVEL_W = 2;
    localparam int DELTA_W = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    // Wide enough to hold a button count of up to 65535
    localparam int ADDR_EXT_W = 16;

    // Result classes
    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_PRESSED = 2'd1,
        CLS_RAPID   = 2'd2,
        CLS_HOLD    = 2'd3
    } t_class;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_FRAMES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD_US    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_WINDOW_US    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_COUNT_NEEDED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_US       = 3'd4;

    // Register values after reset
    localparam logic [COUNT_W-1:0] RST_BUFFER_FRAMES      = 8'd3;
    localparam logic [TIME_W-1:0]  RST_FRAME_PERIOD_US    = 32'd16667;
    localparam logic [TIME_W-1:0]  RST_RAPID_WINDOW_US    = 32'd200000;
    localparam logic [COUNT_W-1:0] RST_RAPID_COUNT_NEEDED = 8'd4;
    localparam logic [TIME_W-1:0]  RST_HOLD_TIME_US       = 32'd500000;

    // Live configuration
    typedef struct packed {
        logic [COUNT_W-1:0] buffer_frames;
        logic [TIME_W-1:0]  frame_period_us;
        logic [TIME_W-1:0]  rapid_window_us;
        logic [COUNT_W-1:0] rapid_count_needed;
        logic [TIME_W-1:0]  hold_time_us;
    } t_cfg;

    // One stored button entry
    typedef struct packed {
        logic [LEVEL_W-1:0] last_level;
        logic [TIME_W-1:0]  stable_time;
        logic [COUNT_W-1:0] buffered_count;
        logic [COUNT_W-1:0] rapid_count;
        t_class             last_class;
    } t_entry;

    // Increment that sticks at all ones
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

FILE: hdl/bpc_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the classifier.
interface bpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::IDX_W-1:0]   button_index;
    logic [bpc_pkg::LEVEL_W-1:0] key_level;
    logic [bpc_pkg::DELTA_W-1:0] delta_time_us;

    modport source (output valid, button_index, key_level, delta_time_us, input ready);
    modport sink   (input valid, button_index, key_level, delta_time_us, output ready);
endinterface

interface bpc_out_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::IDX_W-1:0]   button_index_out;
    logic [1:0]                  button_class;

    modport source (output valid, button_index_out, button_class, input ready);
    modport sink   (input valid, button_index_out, button_class, output ready);
endinterface

FILE: hdl/button_press_hold_rapid_classifier.sv
`timescale 1ns / 1ps
// Top level of the button press/hold/rapid classifier.
// Takes one button update per cycle while no stall holds it and returns one class per update.
// On acceptance the button's entry is read from the state memory; the update stage then
// updates it, writes it back and loads the output register. An update for the same button
// in the very next cycle is served by a bypass of the write, so back-to-back updates never
// stall; apart from the clearing after reset, the only stall is a full output register that
// is not being taken. After reset the block clears every entry of its state memory and takes
// no update during that time; configuration writes are taken throughout. An index at or
// above NUM_BUTTONS changes no state and returns class none.
module button_press_hold_rapid_classifier #(
    parameter int NUM_BUTTONS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bpc_in_if.sink                           i_item,
    bpc_out_if.source                        o_result,
    input  logic                             i_cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bpc_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    t_cfg              cfg;
    logic              busy;
    logic              accept;
    logic              adv;
    logic              retire;
    logic [ADDR_EXT_W-1:0] idx_ext;
    logic [AW-1:0]     rd_addr;
    t_entry            rd_entry;
    t_entry            upd_entry;
    t_class            upd_class;

    logic              r_s1_valid;
    logic              r_s1_in_range;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [AW-1:0]     r_s1_addr;
    logic [LEVEL_W-1:0] r_s1_level;
    logic [DELTA_W-1:0] r_s1_delta;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    t_class            r_out_class;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: the update stage moves on when the output register is free or drains
    assign adv          = !r_out_valid || o_result.ready;
    assign retire       = r_s1_valid && adv;
    assign i_item.ready = !busy && (!r_s1_valid || adv);
    assign accept       = i_item.valid && i_item.ready;

    assign idx_ext = {{(ADDR_EXT_W - IDX_W){1'b0}}, i_item.button_index};
    assign rd_addr = idx_ext[AW-1:0];

    bpc_state_mem #(
        .DEPTH (NUM_BUTTONS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (retire && r_s1_in_range),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (upd_entry),
        .o_busy    (busy)
    );

    bpc_update u_upd (
        .i_entry (rd_entry),
        .i_level (r_s1_level),
        .i_delta (r_s1_delta),
        .i_cfg   (cfg),
        .o_entry (upd_entry),
        .o_class (upd_class)
    );

    // Hold the request in the update stage while its entry is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx      <= i_item.button_index;
            r_s1_addr     <= rd_addr;
            r_s1_level    <= i_item.key_level;
            r_s1_delta    <= i_item.delta_time_us;
            r_s1_in_range <= (idx_ext < ADDR_EXT_W'(NUM_BUTTONS));
        end
    end

    // Load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (retire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_idx   <= r_s1_idx;
            r_out_class <= r_s1_in_range ? upd_class : CLS_NONE;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.button_index_out = r_out_idx;
    assign o_result.button_class     = r_out_class;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !accept)
        else $error("request accepted during state clearing");

    a_retire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        retire |=> o_result.valid)
        else $error("retired request produced no result");

    a_out_of_range_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (retire && !r_s1_in_range) |=> (o_result.button_class == CLS_NONE))
        else $error("out-of-range index reported a class");
`endif

endmodule

FILE: hdl/bpc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the classifier.
module bpc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bpc_pkg::t_cfg                     o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_frames      <= RST_BUFFER_FRAMES;
            r_cfg.frame_period_us    <= RST_FRAME_PERIOD_US;
            r_cfg.rapid_window_us    <= RST_RAPID_WINDOW_US;
            r_cfg.rapid_count_needed <= RST_RAPID_COUNT_NEEDED;
            r_cfg.hold_time_us       <= RST_HOLD_TIME_US;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BUFFER_FRAMES:      r_cfg.buffer_frames      <= i_cfg_data[COUNT_W-1:0];
                CFG_FRAME_PERIOD_US:    r_cfg.frame_period_us    <= i_cfg_data[TIME_W-1:0];
                CFG_RAPID_WINDOW_US:    r_cfg.rapid_window_us    <= i_cfg_data[TIME_W-1:0];
                CFG_RAPID_COUNT_NEEDED: r_cfg.rapid_count_needed <= i_cfg_data[COUNT_W-1:0];
                CFG_HOLD_TIME_US:       r_cfg.hold_time_us       <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/bpc_state_mem.sv
`timescale 1ns / 1ps
// Per-button state memory with clearing sweep and write-to-read bypass.
module bpc_state_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output bpc_pkg::t_entry  o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  bpc_pkg::t_entry  i_wr_data,
    output logic             o_busy
);
    import bpc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr_addr;
    t_entry         mem [DEPTH];
    t_entry         r_rd_data;
    t_entry         r_byp_data;
    logic           r_byp_hit;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    t_entry         wr_data;
    logic           clr_last;

    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    // Advance the clearing sweep after reset
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Select the sweep or the update as the write source
    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // Hold the array; read returns the old entry on a same-edge write
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_rd_en) r_rd_data <= mem[i_rd_addr];
    end

    // Capture a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= wr_en && (wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_byp_data <= wr_data;
    end

    assign o_rd_data = r_byp_hit ? r_byp_data : r_rd_data;
    assign o_busy    = (r_state != ST_RUN);

`ifndef SYNTHESIS
    a_no_read_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_rd_en)
        else $error("state read issued during clearing sweep");
`endif

endmodule

FILE: hdl/bpc_update.sv
`timescale 1ns / 1ps
// Next-state and class computation for one button update.
module bpc_update (
    input  bpc_pkg::t_entry                 i_entry,
    input  logic [bpc_pkg::LEVEL_W-1:0]     i_level,
    input  logic [bpc_pkg::DELTA_W-1:0]     i_delta,
    input  bpc_pkg::t_cfg                   i_cfg,
    output bpc_pkg::t_entry                 o_entry,
    output bpc_pkg::t_class                 o_class
);
    import bpc_pkg::*;

    logic              down, clean, changed, buffered;
    logic [TIME_W:0]   sum_wide;
    logic [TIME_W-1:0] st_sum;
    logic              frame_step;
    logic              st_zero;
    logic              rapid_act;
    logic [COUNT_W-1:0] rapid_inc;
    t_class            cls;

    always_comb begin
        down     = (i_level != '0);
        clean    = (i_entry.last_class == CLS_NONE);
        changed  = (i_level != i_entry.last_level);
        buffered = (i_entry.buffered_count < i_cfg.buffer_frames);

        // Accumulate stable time, sticking at all ones
        sum_wide = {1'b0, i_entry.stable_time} + {{(TIME_W - DELTA_W + 1){1'b0}}, i_delta};
        st_sum   = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

        // Step a buffered frame once a frame period has gone by
        frame_step = !changed && buffered && (st_sum > i_cfg.frame_period_us);
        st_zero    = changed || frame_step;

        // Rapid activity: compare the final stable time (zero or the sum)
        rapid_act = changed || (frame_step ? (i_cfg.rapid_window_us != '0)
                                           : (st_sum < i_cfg.rapid_window_us));
        rapid_inc = sat_inc(i_entry.rapid_count);

        cls = (!down && ((changed && clean) || buffered)) ? CLS_PRESSED : CLS_NONE;
        if (rapid_act && (rapid_inc > i_cfg.rapid_count_needed)) cls = CLS_RAPID;
        if (down && !st_zero && (st_sum > i_cfg.hold_time_us)) cls = CLS_HOLD;

        o_entry.last_level     = i_level;
        o_entry.stable_time    = st_zero ? '0 : st_sum;
        o_entry.buffered_count = changed ? '0 :
                                 frame_step ? sat_inc(i_entry.buffered_count) :
                                 i_entry.buffered_count;
        o_entry.rapid_count    = rapid_act ? rapid_inc : '0;
        o_entry.last_class     = cls;
        o_class                = cls;
    end

endmodule
